// ----- hdl/nhra_pkg.sv -----
// Shared constants, types and handshake structures of the nearest cluster head block.
package nhra_pkg;

    localparam int MAX_HEADS_DEF = 64;
    localparam int ID_W          = 10;
    localparam int COORD_W       = 16;
    localparam int RANGE_W       = 16;
    localparam int SQ_W          = 2 * COORD_W;
    localparam int DIST_W        = SQ_W + 1;
    localparam int CMD_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } head_t;

    localparam int HEAD_W = $bits(head_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic start_query;
        logic scan_rd;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic empty;
        logic scan_last;
        logic pipe_idle;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- hdl/nhra_if.sv -----
// Channel interfaces for command words, result words and range configuration words.
interface nhra_item_if;
    import nhra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [ID_W-1:0]      node_id;
    logic [COORD_W-1:0]   pos_x;
    logic [COORD_W-1:0]   pos_y;

    modport source (output valid, output command, output node_id, output pos_x,
                    output pos_y, input ready);
    modport sink   (input valid, input command, input node_id, input pos_x,
                    input pos_y, output ready);
endinterface

interface nhra_result_if;
    import nhra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ID_W-1:0]      head_id;
    logic [DIST_W-1:0]    best_dist_sq;
    logic                 table_full;

    modport source (output valid, output head_id, output best_dist_sq,
                    output table_full, input ready);
    modport sink   (input valid, input head_id, input best_dist_sq,
                    input table_full, output ready);
endinterface

interface nhra_cfg_if;
    import nhra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RANGE_W-1:0]   range_limit;

    modport source (output valid, output range_limit, input ready);
    modport sink   (input valid, input range_limit, output ready);
endinterface

// ----- hdl/nhra_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module nhra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/nhra_ctrl.sv -----
// Controller state machine sequencing command acceptance, table scan and result hand-off.
module nhra_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  nhra_pkg::ctrl_sts_t   sts,
    output nhra_pkg::ctrl_cmd_t   cmd
);
    import nhra_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        item_ready      = 1'b0;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.is_query)
                    begin
                        cmd.start_query = 1'b1;
                        state_next      = sts.empty ? ST_DRAIN : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_idle)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/nhra_dp.sv -----
// Datapath: head table, distance pipeline, best-match tracking and result register.
module nhra_dp #(
    parameter int MAX_HEADS = nhra_pkg::MAX_HEADS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [nhra_pkg::CMD_W-1:0]    item_command,
    input  logic [nhra_pkg::ID_W-1:0]     item_node_id,
    input  logic [nhra_pkg::COORD_W-1:0]  item_pos_x,
    input  logic [nhra_pkg::COORD_W-1:0]  item_pos_y,
    input  logic                          cfg_we,
    input  logic [nhra_pkg::RANGE_W-1:0]  cfg_range_limit,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [nhra_pkg::ID_W-1:0]     out_head_id,
    output logic [nhra_pkg::DIST_W-1:0]   out_best_dist_sq,
    output logic                          out_table_full,
    input  nhra_pkg::ctrl_cmd_t           cmd,
    output nhra_pkg::ctrl_sts_t           sts
);
    import nhra_pkg::*;

    localparam int AW = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
    localparam int CW = $clog2(MAX_HEADS + 1);

    // Configuration and table bookkeeping.
    logic [RANGE_W-1:0] range_reg;
    logic [SQ_W-1:0]    range_sq_reg;
    logic [CW-1:0]      count_reg;
    logic               ovf_reg;

    // Query position and scan pointer.
    logic [COORD_W-1:0] qx_reg;
    logic [COORD_W-1:0] qy_reg;
    logic [CW-1:0]      scan_idx_reg;

    // Distance pipeline.
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               v4_reg;
    head_t              rd_head;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [ID_W-1:0]    id2_reg;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;
    logic [ID_W-1:0]    id3_reg;
    logic [DIST_W-1:0]  sum_reg;
    logic [ID_W-1:0]    id4_reg;

    // Best match so far.
    logic               found_reg;
    logic [DIST_W-1:0]  best_reg;
    logic [ID_W-1:0]    best_id_reg;

    // Result register.
    logic               out_valid_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               out_full_reg;

    logic               is_clear;
    logic               is_add;
    logic               add_ok;
    logic               add_drop;
    logic               better;
    head_t              wr_head;

    assign is_clear = cmd.accept && (item_command == CMD_CLEAR);
    assign is_add   = cmd.accept && (item_command == CMD_ADD) && (item_node_id != '0);
    assign add_ok   = is_add && (count_reg != CW'(MAX_HEADS));
    assign add_drop = is_add && (count_reg == CW'(MAX_HEADS));

    assign wr_head.id = item_node_id;
    assign wr_head.x  = item_pos_x;
    assign wr_head.y  = item_pos_y;

    nhra_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (MAX_HEADS)
    ) u_store (
        .clk   (clk),
        .we    (add_ok),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_head),
        .re    (cmd.scan_rd),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (rd_head)
    );

    assign better = v4_reg && (sum_reg <= {1'b0, range_sq_reg})
                    && (!found_reg || (sum_reg < best_reg));

    assign sts.is_query  = (item_command == CMD_QUERY);
    assign sts.empty     = (count_reg == '0);
    assign sts.scan_last = (CW'(scan_idx_reg + CW'(1)) == count_reg);
    assign sts.pipe_idle = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg     <= '0;
            range_sq_reg  <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            scan_idx_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                range_reg <= cfg_range_limit;
            end
            range_sq_reg <= SQ_W'(range_reg) * SQ_W'(range_reg);

            if (is_clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (add_ok)
            begin
                count_reg <= CW'(count_reg + CW'(1));
            end
            else if (add_drop)
            begin
                ovf_reg <= 1'b1;
            end

            if (cmd.start_query)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_idx_reg <= CW'(scan_idx_reg + CW'(1));
            end

            v1_reg <= cmd.scan_rd;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;

            if (cmd.start_query)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            qx_reg <= item_pos_x;
            qy_reg <= item_pos_y;
        end

        dx_reg  <= (qx_reg >= rd_head.x) ? (qx_reg - rd_head.x) : (rd_head.x - qx_reg);
        dy_reg  <= (qy_reg >= rd_head.y) ? (qy_reg - rd_head.y) : (rd_head.y - qy_reg);
        id2_reg <= rd_head.id;

        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        id3_reg <= id2_reg;

        sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        id4_reg <= id3_reg;

        if (cmd.start_query)
        begin
            best_reg    <= '0;
            best_id_reg <= '0;
        end
        else if (better)
        begin
            best_reg    <= sum_reg;
            best_id_reg <= id4_reg;
        end

        if (cmd.load_out)
        begin
            out_id_reg   <= best_id_reg;
            out_dist_reg <= best_reg;
            out_full_reg <= ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_head_id      = out_id_reg;
    assign out_best_dist_sq = out_dist_reg;
    assign out_table_full   = out_full_reg;

    // The table never holds more heads than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_HEADS))
        else $error("head count beyond table depth");

    // A scan only reads entries that have been written since the last clear.
    a_scan_written: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> (scan_idx_reg < count_reg))
        else $error("scan read beyond stored heads");

    // The result is taken only once every distance has left the pipeline.
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (sts.pipe_idle && !cmd.scan_rd))
        else $error("result loaded while distances in flight");

    // A clear empties the table and drops the overflow mark.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        is_clear |=> (count_reg == '0) && !ovf_reg)
        else $error("clear did not empty the table");

endmodule

// ----- hdl/nearest_head_in_range_assign.sv -----
// Top level of the nearest in-range cluster head lookup block.
//
// Usage: command words arrive on the item channel (valid/ready). A clear word
// empties the head table and drops the overflow mark; an add word with a
// nonzero node id appends a head, or sets the overflow mark when the table
// already holds MAX_HEADS heads; command code three and adds with id zero are
// ignored. Clear and add words are taken in the idle state and give no result.
// A query word scans the stored heads in the order they were added, one head
// per cycle from the table RAM, through a four-stage distance pipeline, and
// produces one result word: the id and squared distance of the nearest head
// within range_limit (earlier head wins ties), or zero for both when none is.
// With heads stored, the result word is loaded once the scan has ended and
// the pipeline has drained; on an empty table the scan is skipped.
// The next word can be taken as soon as the result word appears. The range
// is written on the cfg channel, which is always ready, and must only change
// while the block is idle.
// Reset empties the table, clears the overflow mark and sets the range to
// zero. The result word sits in an output register: while the receiver
// stalls, clear and add words are still taken, and a further query runs its
// scan and then waits until the held result word has been taken.
module nearest_head_in_range_assign #(
    parameter int MAX_HEADS = nhra_pkg::MAX_HEADS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    nhra_item_if.sink      item,
    nhra_result_if.source  result,
    nhra_cfg_if.sink       cfg
);
    import nhra_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    ctrl_sts_t ctrl_sts;

    // The range register is a plain write; it can always be taken.
    assign cfg.ready = 1'b1;

    // The controller decides when a command word is taken and steps the scan.
    nhra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (ctrl_sts),
        .cmd        (ctrl_cmd)
    );

    // The datapath owns the head table, the distance pipeline and the result
    // register, and reports back what the controller needs to sequence.
    nhra_dp #(
        .MAX_HEADS (MAX_HEADS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_command     (item.command),
        .item_node_id     (item.node_id),
        .item_pos_x       (item.pos_x),
        .item_pos_y       (item.pos_y),
        .cfg_we           (cfg.valid && cfg.ready),
        .cfg_range_limit  (cfg.range_limit),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .out_head_id      (result.head_id),
        .out_best_dist_sq (result.best_dist_sq),
        .out_table_full   (result.table_full),
        .cmd              (ctrl_cmd),
        .sts              (ctrl_sts)
    );

endmodule

// ----- sim/nhra_checker.sv -----
// Passive checker that predicts every result word of the nearest head block and compares it.
module nhra_checker
    import nhra_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    nhra_item_if   item,
    nhra_result_if result,
    nhra_cfg_if    cfg,
    output int     mismatches,
    output int     pending
);

    typedef struct packed {
        logic [ID_W-1:0]   head_id;
        logic [DIST_W-1:0] dist_sq;
        logic              table_full;
    } answer_t;

    // Own copy of the head table, its fill level, the overflow mark and the range.
    head_t              tbl [MAX_HEADS_DEF];
    int                 tbl_fill;
    logic               dropped_add;
    logic [RANGE_W-1:0] radius;
    answer_t            answers_due [$];
    answer_t            want;
    int                 bad;

    function automatic logic [DIST_W-1:0] gap_sq(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
        logic [DIST_W-1:0] d;
        d = (a >= b) ? DIST_W'(a - b) : DIST_W'(b - a);
        return d * d;
    endfunction

    // Scans the table in insertion order; a strictly smaller distance is needed to
    // displace an earlier head, so ties go to the older entry.
    function automatic answer_t nearest_in_range(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
        answer_t           a;
        logic [DIST_W-1:0] r;
        logic [DIST_W-1:0] lim;
        logic [DIST_W-1:0] d;
        logic              hit;
        r            = DIST_W'(radius);
        lim          = r * r;
        a.head_id    = '0;
        a.dist_sq    = '0;
        a.table_full = dropped_add;
        hit          = 1'b0;
        for (int i = 0; i < tbl_fill; i++)
        begin
            d = gap_sq(px, tbl[i].x) + gap_sq(py, tbl[i].y);
            if (d <= lim && (!hit || d < a.dist_sq))
            begin
                hit       = 1'b1;
                a.dist_sq = d;
                a.head_id = tbl[i].id;
            end
        end
        return a;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] expected_val, logic [63:0] actual_val);
        bad++;
        if (bad <= 10)
            $display("mismatch %0d at %0t: %s expected %0d, got %0d",
                     bad, $realtime, what, expected_val, actual_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_fill    = 0;
            dropped_add = 1'b0;
            radius      = '0;
            bad         = 0;
            answers_due.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (answers_due.size() == 0)
                    note_mismatch("result word with nothing due, head_id", '0, result.head_id);
                else
                begin
                    want = answers_due[0];
                    answers_due.delete(0);
                    if (result.head_id !== want.head_id)
                        note_mismatch("head_id", want.head_id, result.head_id);
                    if (result.best_dist_sq !== want.dist_sq)
                        note_mismatch("best_dist_sq", want.dist_sq, result.best_dist_sq);
                    if (result.table_full !== want.table_full)
                        note_mismatch("table_full", want.table_full, result.table_full);
                end
            end

            if (cfg.valid && cfg.ready)
                radius = cfg.range_limit;

            if (item.valid && item.ready)
            begin
                case (cmd_t'(item.command))
                    CMD_CLEAR:
                    begin
                        tbl_fill    = 0;
                        dropped_add = 1'b0;
                    end
                    CMD_ADD:
                    begin
                        if (item.node_id != '0)
                        begin
                            if (tbl_fill >= MAX_HEADS_DEF)
                                dropped_add = 1'b1;
                            else
                            begin
                                tbl[tbl_fill].id = item.node_id;
                                tbl[tbl_fill].x  = item.pos_x;
                                tbl[tbl_fill].y  = item.pos_y;
                                tbl_fill++;
                            end
                        end
                    end
                    CMD_QUERY:
                        answers_due.insert(answers_due.size(),
                                           nearest_in_range(item.pos_x, item.pos_y));
                    default:
                        ;
                endcase
            end

            mismatches <= bad;
            pending    <= answers_due.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the simulation: clock, reset, command and range stimulus, and the final verdict.
module testbench;
    import nhra_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    // Long enough for a query over a full table to run its scan and drain the pipeline.
    localparam int SETTLE       = MAX_HEADS_DEF + 10;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    nhra_item_if   item ();
    nhra_result_if result ();
    nhra_cfg_if    cfg ();

    int mismatches;
    int pending;

    // Idling percentages of the sender and the receiver, changed per phase.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // The stimulus flips hold_toggle to ask the receiver for a long hold-off;
    // the ready process notices the change and counts the stretch down itself.
    bit hold_toggle = 1'b0;
    bit hold_seen   = 1'b0;
    int hold_left   = 0;

    int cycles = 0;

    // Words that do real work (not command three and not adds with id zero).
    int useful = 0;
    int blocks = 0;

    // Positions of the heads currently stored, used only to aim queries and
    // new heads near existing ones so that the range test is exercised.
    logic [COORD_W-1:0] placed_x [$];
    logic [COORD_W-1:0] placed_y [$];
    logic [RANGE_W-1:0] cur_range = '0;

    nearest_head_in_range_assign u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    nhra_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg        (cfg),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    // Every input of the block has a known value from time zero.
    initial
    begin
        item.valid         = 1'b0;
        item.command       = CMD_CLEAR;
        item.node_id       = '0;
        item.pos_x         = '0;
        item.pos_y         = '0;
        result.ready       = 1'b0;
        cfg.valid          = 1'b0;
        cfg.range_limit    = '0;
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_seen != hold_toggle)
        begin
            hold_seen    <= hold_toggle;
            hold_left    <= HOLD_CYCLES;
            result.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one command word, with random idle cycles ahead of it, and returns
    // at the edge where it is taken. Valid stays high so back-to-back words
    // follow one another without a gap.
    task automatic send_word(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                             logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid   <= 1'b1;
        item.command <= c;
        item.node_id <= id;
        item.pos_x   <= x;
        item.pos_y   <= y;
        do
            @(posedge clk);
        while (!item.ready);
        if (c == CMD_CLEAR)
        begin
            placed_x.delete();
            placed_y.delete();
        end
        else if (c == CMD_ADD && id != '0 && placed_x.size() < MAX_HEADS_DEF)
        begin
            placed_x.insert(placed_x.size(), x);
            placed_y.insert(placed_y.size(), y);
        end
        if (c != CMD_SPARE && !(c == CMD_ADD && id == '0))
            useful++;
    endtask

    // Stops sending, waits until every expected result word has been taken,
    // then lets the block's longest scan run out before anything else happens.
    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes the range register; only called while the block is idle.
    task automatic set_range(logic [RANGE_W-1:0] r);
        cfg.valid       <= 1'b1;
        cfg.range_limit <= r;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        cur_range = r;
    endtask

    // Moves a coordinate by up to reach in either direction, clamped to the field.
    function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] base, int unsigned reach);
        int v;
        v = int'(base);
        if ($urandom_range(1))
            v = v + int'($urandom_range(reach));
        else
            v = v - int'($urandom_range(reach));
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[COORD_W-1:0];
    endfunction

    // Head positions: fully random, clustered around an existing head, or an
    // exact copy of one so that equal distances occur.
    task automatic pick_head_spot(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
        int k;
        int idx;
        k = $urandom_range(9);
        if (placed_x.size() == 0 || k < 4)
        begin
            x = COORD_W'($urandom_range(65535));
            y = COORD_W'($urandom_range(65535));
        end
        else
        begin
            idx = $urandom_range(placed_x.size() - 1);
            if (k == 4)
            begin
                x = placed_x[idx];
                y = placed_y[idx];
            end
            else
            begin
                x = nudge(placed_x[idx], 2 * int'(cur_range) + 8);
                y = nudge(placed_y[idx], 2 * int'(cur_range) + 8);
            end
        end
    endtask

    // Query positions: mostly close to a stored head at about the range, some
    // exactly on a head, the rest anywhere.
    task automatic pick_query_spot(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
        int          k;
        int          idx;
        int unsigned reach;
        k = $urandom_range(9);
        if (placed_x.size() == 0 || k < 3)
        begin
            x = COORD_W'($urandom_range(65535));
            y = COORD_W'($urandom_range(65535));
        end
        else
        begin
            idx   = $urandom_range(placed_x.size() - 1);
            reach = (k == 3) ? 0 : (int'(cur_range) * 3 / 4 + 1);
            x     = nudge(placed_x[idx], reach);
            y     = nudge(placed_y[idx], reach);
        end
    endtask

    // Noise: command three, or an add with id zero, both with random fields.
    task automatic send_noise();
        if ($urandom_range(1))
            send_word(CMD_SPARE, ID_W'($urandom_range(1023)), COORD_W'($urandom_range(65535)),
                      COORD_W'($urandom_range(65535)));
        else
            send_word(CMD_ADD, '0, COORD_W'($urandom_range(65535)),
                      COORD_W'($urandom_range(65535)));
    endtask

    task automatic send_query();
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
        pick_query_spot(qx, qy);
        send_word(CMD_QUERY, '0, qx, qy);
    endtask

    // Random traffic in well-formed blocks: usually a clear, a run of adds with
    // the odd query and noise word among them, then a burst of queries. Every
    // twelfth block adds 60 to 70 heads, which may overrun the table and set the
    // overflow mark; sometimes the clear is left out and the table keeps growing.
    task automatic run_blocks(int goal);
        int n;
        int m;
        logic [COORD_W-1:0] hx;
        logic [COORD_W-1:0] hy;
        while (useful < goal)
        begin
            blocks++;
            if ($urandom_range(99) < 85)
                send_word(CMD_CLEAR, ID_W'($urandom_range(1023)),
                          COORD_W'($urandom_range(65535)), COORD_W'($urandom_range(65535)));
            if (blocks % 12 == 0)
                n = $urandom_range(60, 70);
            else if ($urandom_range(19) == 0)
                n = 0;
            else
                n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(99) < 5)
                    send_noise();
                if ($urandom_range(99) < 10)
                    send_query();
                pick_head_spot(hx, hy);
                send_word(CMD_ADD, ID_W'($urandom_range(1, 1023)), hx, hy);
            end
            m = $urandom_range(1, 6);
            for (int i = 0; i < m; i++)
                send_query();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words with the range at its reset value of zero: query on an
        // empty table, ignored words, then only exact hits count.
        send_word(CMD_QUERY, '0, '0, '0);
        send_word(CMD_ADD, '0, 16'd100, 16'd100);
        send_word(CMD_SPARE, 10'h3FF, 16'hFFFF, 16'hFFFF);
        send_word(CMD_QUERY, '0, 16'd100, 16'd100);
        send_word(CMD_ADD, 10'd1023, 16'd0, 16'd0);
        send_word(CMD_ADD, 10'd5, 16'hFFFF, 16'hFFFF);
        send_word(CMD_ADD, 10'd7, 16'd0, 16'd0);
        send_word(CMD_QUERY, '0, 16'd0, 16'd0);
        send_word(CMD_QUERY, '0, 16'd1, 16'd0);
        send_word(CMD_QUERY, '0, 16'hFFFF, 16'hFFFF);

        // Widest range: heads at exactly the range limit tie, the older wins;
        // a head at the far corner is out of range.
        drain();
        set_range(16'hFFFF);
        send_word(CMD_QUERY, '0, 16'hFFFF, 16'd0);
        send_word(CMD_QUERY, '0, 16'd32768, 16'd32768);
        send_word(CMD_ADD, 10'd1, 16'hFFFF, 16'd0);
        send_word(CMD_QUERY, '0, 16'd0, 16'hFFFF);
        send_word(CMD_CLEAR, '0, '0, '0);
        send_word(CMD_QUERY, '0, 16'd1234, 16'd4321);
        send_word(CMD_ADD, 10'd12, 16'd40000, 16'd40000);
        send_word(CMD_QUERY, '0, 16'd0, 16'd0);

        // Range of one: distance squared one is in, two is out.
        drain();
        set_range(16'd1);
        send_word(CMD_QUERY, '0, 16'd40001, 16'd40000);
        send_word(CMD_QUERY, '0, 16'd40001, 16'd40001);

        // First random phase: the sender idles a little, the receiver a lot.
        // Part-way through, the receiver holds off for a long stretch while
        // words keep coming, so the block fills and stops taking words.
        drain();
        set_range(RANGE_W'($urandom_range(500, 5000)));
        tx_idle_pct = 28;
        rx_idle_pct = 65;
        run_blocks(useful + 60);
        hold_toggle = ~hold_toggle;
        run_blocks(useful + 160);

        // The sender pauses here until every result word is back.
        drain();
        set_range(16'hFFFF);
        tx_idle_pct = 65;
        rx_idle_pct = 28;
        run_blocks(useful + 215);

        // Last phase with no idling on either side, first at range zero and
        // then at a small random range.
        drain();
        set_range('0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_blocks(useful + 100);
        drain();
        set_range(RANGE_W'($urandom_range(20, 400)));
        run_blocks(useful + 115);

        drain();
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
